@@ rtl/rhc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the RGB to HSV converter.
// Used by rhc_div_pipe and rgb_to_hsv_convert_top; depends on nothing else.
package rhc_pkg;

  // Quotient widths: saturation is 0..4095, the hue offset is 0..60 degrees.
  localparam int SAT_Q_W    = 12;
  localparam int HUE_Q_W    = 6;
  // Divider stages; each retires an equal share of both quotients.
  localparam int DIV_STAGES = 3;
  localparam int SAT_STEPS  = SAT_Q_W / DIV_STAGES;
  localparam int HUE_STEPS  = HUE_Q_W / DIV_STAGES;

  localparam logic [9:0] BASE_RED       = 10'd0;
  localparam logic [9:0] BASE_GREEN     = 10'd120;
  localparam logic [9:0] BASE_BLUE      = 10'd240;
  localparam logic [9:0] HUE_FULL_TURN  = 10'd360;

  // Which channel holds the maximum, with red winning ties over green over blue.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One pixel on its way through the dividers. Each remainder/word pair is a
  // restoring divider: the word shifts numerator bits out at the top and
  // quotient bits in at the bottom.
  typedef struct packed {
    logic [7:0]         mx;
    logic [7:0]         delta;
    sector_t            sector;
    logic               neg;
    logic [7:0]         srem;
    logic [SAT_Q_W-1:0] sword;
    logic [7:0]         hrem;
    logic [HUE_Q_W-1:0] hword;
  } div_t;

  typedef struct packed {
    logic [7:0] rem;
    logic       qbit;
  } step_t;

  // One restoring division step. The remainder stays below the divisor, so
  // the shifted value stays below twice the divisor and fits after subtraction.
  function automatic step_t div_step(logic [7:0] rem, logic [7:0] den, logic inb);
    logic [8:0] t;
    step_t      r;
    t = {rem, inb};
    if (t >= {1'b0, den}) begin
      r.rem  = 8'(t - {1'b0, den});
      r.qbit = 1'b1;
    end else begin
      r.rem  = t[7:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

  // Work done by one divider stage on both quotients.
  function automatic div_t div_advance(div_t d);
    div_t  r;
    step_t s;
    r = d;
    for (int k = 0; k < SAT_STEPS; k++) begin
      s       = div_step(r.srem, r.mx, r.sword[SAT_Q_W-1]);
      r.srem  = s.rem;
      r.sword = {r.sword[SAT_Q_W-2:0], s.qbit};
    end
    for (int k = 0; k < HUE_STEPS; k++) begin
      s       = div_step(r.hrem, r.delta, r.hword[HUE_Q_W-1]);
      r.hrem  = s.rem;
      r.hword = {r.hword[HUE_Q_W-2:0], s.qbit};
    end
    return r;
  endfunction

endpackage

@@ rtl/rhc_div_pipe.sv @@
// Pipelined restoring dividers for saturation and hue, DIV_STAGES register stages.
// Depends on rhc_pkg for the stage payload type and the division step.
module rhc_div_pipe (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rhc_pkg::div_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rhc_pkg::div_t out_data
);
  import rhc_pkg::*;

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES:0]   rdy;
  logic [DIV_STAGES-1:0] vin;
  div_t                  src [DIV_STAGES];
  div_t                  st  [DIV_STAGES];

  assign src[0]          = in_data;
  assign vin[0]          = in_valid;
  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];
  assign out_valid       = v[DIV_STAGES-1];
  assign out_data        = st[DIV_STAGES-1];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    div_t nxt;

    assign nxt        = div_advance(src[i]);
    // A stage takes a new beat when it is empty or its own beat moves on.
    assign rdy[i]     = !v[i] || rdy[i+1];

    if (i > 0) begin : g_link
      assign src[i] = st[i-1];
      assign vin[i] = v[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st[i] <= nxt;
      end
    end
  end

endmodule

@@ rtl/rgb_to_hsv_convert_top.sv @@
// Top level of the RGB to HSV converter: front stage, divider pipeline, output register.
// Depends on rhc_pkg and rhc_div_pipe.
//
// Usage: one RGB pixel enters per beat on the input channel (in_valid/in_ready with
// red, green, blue) and one HSV result leaves per beat on the output channel
// (out_valid/out_ready with hue, saturation, brightness). Brightness is the largest
// channel, saturation is 4095*(max-min)/max truncated, and hue is in 1/64 degree.
// Path: a pixel accepted at the input passes s1, the three divider stages and the
// output register before out_valid rises. Throughput: one pixel per clock cycle
// while out_ready is high. The rate is set by the divider pipeline: three stages,
// each retiring four saturation quotient bits and two hue quotient bits.
// Every stage has its own valid bit and takes a new beat whenever it is empty or
// its beat moves on, so bubbles close up while the receiver stalls; in_ready only
// falls once all five stages hold a pixel and out_ready is low. Nothing is dropped
// or repeated during a stall.
// Reset (rst, synchronous, active high) empties every stage; no result is pending
// after reset and the block has no other state.
module rgb_to_hsv_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] hue,
  output logic [11:0] saturation,
  output logic [7:0]  brightness
);
  import rhc_pkg::*;

  // Front stage: extremes, sector, signed difference, and both numerators.
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [7:0]  pa;
  logic [7:0]  pb;
  logic [7:0]  mag;
  logic        neg;
  sector_t     sec;
  logic [19:0] sat_num;
  logic [13:0] hue_num;
  div_t        prep;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    // Ties go to red first, then green.
    if (mx == red) begin
      sec = SECT_RED;
    end else if (mx == green) begin
      sec = SECT_GREEN;
    end else begin
      sec = SECT_BLUE;
    end

    unique case (sec)
      SECT_RED: begin
        pa = green;
        pb = blue;
      end
      SECT_GREEN: begin
        pa = blue;
        pb = red;
      end
      default: begin
        pa = red;
        pb = green;
      end
    endcase

    neg = pa < pb;
    mag = neg ? (pb - pa) : (pa - pb);

    // 4095*delta and 60*mag by shifts and one subtraction each.
    sat_num = {delta, 12'b0} - {12'b0, delta};
    hue_num = {mag, 6'b0} - {4'b0, mag, 2'b0};

    // Both quotients are known to fit their widths, so the upper numerator bits
    // already form a remainder below the divisor.
    prep.mx     = mx;
    prep.delta  = delta;
    prep.sector = sec;
    prep.neg    = neg;
    prep.srem   = sat_num[19:SAT_Q_W];
    prep.sword  = sat_num[SAT_Q_W-1:0];
    prep.hrem   = hue_num[13:HUE_Q_W];
    prep.hword  = hue_num[HUE_Q_W-1:0];
  end

  logic  s1_valid;
  logic  s1_load;
  div_t  s1;
  logic  div_in_ready;
  logic  div_out_valid;
  logic  div_out_ready;
  div_t  div_out;

  assign s1_load  = !s1_valid || div_in_ready;
  assign in_ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= prep;
    end
  end

  rhc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (div_in_ready),
    .in_data   (s1),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_data  (div_out)
  );

  // Final stage: place the hue offset around its sector base and wrap negatives.
  logic [9:0]        base;
  logic [9:0]        qx;
  logic signed [9:0] hdeg;
  logic [14:0]       hue_next;
  logic [11:0]       sat_next;
  logic              out_load;

  always_comb begin
    unique case (div_out.sector)
      SECT_RED:   base = BASE_RED;
      SECT_GREEN: base = BASE_GREEN;
      default:    base = BASE_BLUE;
    endcase
    qx   = {{(10-HUE_Q_W){1'b0}}, div_out.hword};
    hdeg = div_out.neg ? signed'(base - qx) : signed'(base + qx);
    if (hdeg < 0) begin
      hdeg = hdeg + signed'(HUE_FULL_TURN);
    end
    // A gray pixel has no hue, and black has no saturation.
    hue_next = (div_out.delta == 8'd0) ? 15'd0 : {hdeg[8:0], 6'b0};
    sat_next = (div_out.mx == 8'd0) ? 12'd0 : div_out.sword;
  end

  assign out_load      = !out_valid || out_ready;
  assign div_out_ready = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && div_out_valid) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= div_out.mx;
    end
  end

`ifndef NO_ASSERTIONS
  // Backpressure only ever comes from the receiver, through a full pipeline.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while the pipeline has room");

  // Hue always lands below a full turn and on whole-degree steps.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < 15'd23040 && hue[5:0] == 6'd0))
    else $error("hue out of range");

  // A black pixel carries neither hue nor saturation.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && brightness == 8'd0) |-> (saturation == 12'd0 && hue == 15'd0))
    else $error("black pixel with nonzero hue or saturation");

  // A beat taken by the output register while it was free shows up next cycle.
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    (out_load && div_out_valid) |=> out_valid)
    else $error("result lost on its way into the output register");
`endif

endmodule
